// File: rtl/fpr_pkg.sv
package fpr_pkg;

    localparam int TICK_W = 63;
    localparam int RATE_W = 28;
    localparam int DT_W   = 32;
    localparam int REG_W  = 32;
    localparam int IDX_W  = 2;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
    localparam logic [REG_W-1:0]  CNT_MAX  = {REG_W{1'b1}};

    // register indexes
    localparam logic [IDX_W-1:0] REG_BLOCK_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_CAP_ENABLE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_FRAME_PERIOD = 2'd2;
    localparam logic [IDX_W-1:0] REG_TICKS_PER_S  = 2'd3;

    localparam logic [REG_W-1:0] TPS_RESET = 32'd10000000;

    typedef struct packed {
        logic              kind;
        logic [TICK_W-1:0] now_tick;
        logic [DT_W-1:0]   sim_frame_time;
    } req_t;

    typedef struct packed {
        logic [TICK_W-1:0] release_tick;
        logic [RATE_W-1:0] draw_rate;
        logic [RATE_W-1:0] sim_rate;
    } rsp_t;

endpackage

// File: rtl/frame_pacer_with_rate_meter.sv
// channel | direction | handshake           | word
// req     | in        | req_valid/req_stall | fpr_pkg::req_t
// rsp     | out       | rsp_valid/rsp_stall | fpr_pkg::rsp_t
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one word at a time; a word holds the sequencer through a pacing step, then up to
// three runs of the shared restoring divider at one quotient bit per cycle, each with
// a launch and a finish step, as many as the rate samples taken need; each 0.9/0.1
// blend adds a step of its own
// rst_n clears the schedule and the meters and returns the registers to their reset values at once
// rsp holds a result in its own register; the next req word is taken while
// it waits, and the sequencer parks before delivery until rsp is free
module frame_pacer_with_rate_meter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  fpr_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output fpr_pkg::rsp_t                 rsp,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpr_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fpr_pkg::REG_W-1:0]     cfg_data
);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PACE  = 4'd1;
    localparam logic [3:0] S_DRAW  = 4'd2;
    localparam logic [3:0] S_WIN   = 4'd3;
    localparam logic [3:0] S_WDIV  = 4'd4;
    localparam logic [3:0] S_SIM   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DDONE = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_BLEND = 4'd9;

    // what a divider run is for
    localparam logic [2:0] OP_DINST = 3'd0;
    localparam logic [2:0] OP_WIN   = 3'd1;
    localparam logic [2:0] OP_SINST = 3'd2;

    localparam int QB = fpr_pkg::RATE_W;
    localparam int NW = 73;

    logic [3:0]  state_reg, state_next;

    // configuration
    logic        en_reg, cap_reg;
    logic [31:0] period_reg, tps_reg;

    // latched word and release
    logic        kind_reg, kind_next;
    logic [62:0] now_reg, now_next;
    logic [31:0] dt_reg, dt_next;
    logic [62:0] rel_reg, rel_next;

    // pacer and meter state
    logic        started_reg, started_next;
    logic [63:0] slot_reg, slot_next;
    logic [62:0] prev_reg, prev_next;
    logic [62:0] wstart_reg, wstart_next;
    logic [31:0] count_reg, count_next;
    logic [27:0] draw_reg, draw_next;
    logic [27:0] sim_reg, sim_next;
    logic [62:0] elapsed_reg, elapsed_next;
    logic [63:0] prod_reg, prod_next;

    // shared divider
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [QB-1:0] low_reg, low_next;
    logic [QB-1:0] quo_reg, quo_next;
    logic [4:0]  step_reg, step_next;
    logic        sat_reg, sat_next;
    logic [2:0]  op_reg, op_next;

    logic          rsp_valid_reg, rsp_valid_next;
    fpr_pkg::rsp_t rsp_reg, rsp_next;

    // divider launch request
    logic          dstart;
    logic [NW-1:0] dn;
    logic [63:0]   dd;
    logic [2:0]    dop;

    // scratch
    logic [63:0] period64, relw, slot_far, slot_step;
    logic [62:0] delta, span;
    logic        delta_ok;
    logic [32:0] delta_scaled;
    logic [31:0] cinc;
    logic [64:0] trial;
    logic [27:0] qres;
    logic [33:0] b90;
    logic [29:0] b75;
    logic [63:0] q10;
    logic [63:0] dn_hi;

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        now_next       = now_reg;
        dt_next        = dt_reg;
        rel_next       = rel_reg;
        started_next   = started_reg;
        slot_next      = slot_reg;
        prev_next      = prev_reg;
        wstart_next    = wstart_reg;
        count_next     = count_reg;
        draw_next      = draw_reg;
        sim_next       = sim_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        low_next       = low_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        op_next        = op_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        dstart = 1'b0;
        dn     = '0;
        dd     = '0;
        dop    = OP_DINST;

        period64     = (period_reg == 32'd0) ? 64'd1 : {32'd0, period_reg};
        relw         = ({1'b0, now_reg} > slot_reg) ? {1'b0, now_reg} : slot_reg;
        if (relw > {1'b0, {63{1'b1}}})
        begin
            relw = {1'b0, {63{1'b1}}};
        end
        slot_far     = slot_reg + {period64[61:0], 2'b00};
        slot_step    = slot_reg + period64;
        delta        = rel_reg - prev_reg;
        delta_scaled = {20'd0, delta[12:0]} * 33'd1000000;
        delta_ok     = (|delta[62:13]) || (delta_scaled > {1'b0, tps_reg});
        span         = rel_reg - wstart_reg;
        cinc         = (count_reg == fpr_pkg::CNT_MAX) ? count_reg : count_reg + 32'd1;
        trial        = {rem_reg, low_reg[QB-1]};
        qres         = sat_reg ? fpr_pkg::RATE_MAX : quo_reg;
        b90          = 34'd0;
        b75          = 30'd0;
        // divide by ten: exact for any 32-bit dividend
        q10          = {32'd0, prod_reg[31:0]} * 64'h0000_0000_CCCC_CCCD;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    now_next   = req.now_tick;
                    dt_next    = req.sim_frame_time;
                    state_next = S_PACE;
                end
            end
            S_PACE:
            begin
                rel_next = now_reg;
                if (!en_reg)
                begin
                    state_next = S_FIN;
                end
                else if (kind_reg)
                begin
                    // device reset clears every meter and the schedule
                    started_next = 1'b0;
                    slot_next    = '0;
                    prev_next    = '0;
                    wstart_next  = '0;
                    count_next   = '0;
                    draw_next    = '0;
                    sim_next     = '0;
                    state_next   = S_FIN;
                end
                else if (tps_reg == 32'd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DRAW;
                    if (cap_reg)
                    begin
                        if (!started_reg)
                        begin
                            started_next = 1'b1;
                            slot_next    = {1'b0, now_reg} + period64;
                        end
                        else
                        begin
                            rel_next = relw[62:0];
                            // long stall or lagging slot re-seats the phase
                            if (relw > slot_far)
                            begin
                                slot_next = relw + period64;
                            end
                            else if (slot_step < relw)
                            begin
                                slot_next = relw + period64;
                            end
                            else
                            begin
                                slot_next = slot_step;
                            end
                        end
                    end
                end
            end
            S_DRAW:
            begin
                prev_next = rel_reg;
                if (prev_reg != 63'd0 && rel_reg > prev_reg && delta_ok)
                begin
                    dstart = 1'b1;
                    dn     = {33'd0, tps_reg, 8'd0} + {11'd0, delta[62:1]};
                    dd     = {1'b0, delta};
                    dop    = OP_DINST;
                end
                else
                begin
                    state_next = S_WIN;
                end
            end
            S_WIN:
            begin
                state_next = S_SIM;
                if (wstart_reg == 63'd0)
                begin
                    wstart_next = rel_reg;
                    count_next  = cinc;
                end
                else if (rel_reg >= wstart_reg && {1'b0, span} >= {34'd0, tps_reg[31:2]})
                begin
                    count_next   = '0;
                    wstart_next  = rel_reg;
                    elapsed_next = span;
                    prod_next    = {32'd0, cinc} * {32'd0, tps_reg};
                    if (span != 63'd0)
                    begin
                        state_next = S_WDIV;
                    end
                end
                else
                begin
                    count_next = cinc;
                end
            end
            S_WDIV:
            begin
                dstart = 1'b1;
                dn     = {1'b0, prod_reg, 8'd0} + {11'd0, elapsed_reg[62:1]};
                dd     = {1'b0, elapsed_reg};
                dop    = OP_WIN;
            end
            S_SIM:
            begin
                if (dt_reg >= 32'd17)
                begin
                    dstart = 1'b1;
                    dn     = {41'd1, 32'd0} + {42'd0, dt_reg[31:1]};
                    dd     = {32'd0, dt_reg};
                    dop    = OP_SINST;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle
                if (trial >= {1'b0, dvs_reg})
                begin
                    rem_next = trial[63:0] - dvs_reg;
                    quo_next = {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[QB-2:0], 1'b0};
                end
                low_next  = {low_reg[QB-2:0], 1'b0};
                step_next = step_reg - 5'd1;
                if (step_reg == 5'd1)
                begin
                    state_next = S_DDONE;
                end
            end
            S_DDONE:
            begin
                unique case (op_reg)
                    OP_DINST:
                    begin
                        if (draw_reg == 28'd0)
                        begin
                            draw_next  = qres;
                            state_next = S_WIN;
                        end
                        else
                        begin
                            b90        = {3'd0, draw_reg, 3'd0} + {6'd0, draw_reg}
                                         + {6'd0, qres} + 34'd5;
                            prod_next  = {30'd0, b90};
                            state_next = S_BLEND;
                        end
                    end
                    OP_WIN:
                    begin
                        b75 = {1'b0, draw_reg, 1'b0} + {2'd0, draw_reg}
                              + {2'd0, qres} + 30'd2;
                        draw_next  = (draw_reg == 28'd0) ? qres : b75[29:2];
                        state_next = S_SIM;
                    end
                    OP_SINST:
                    begin
                        if (sim_reg == 28'd0)
                        begin
                            sim_next   = qres;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            b90        = {3'd0, sim_reg, 3'd0} + {6'd0, sim_reg}
                                         + {6'd0, qres} + 34'd5;
                            prod_next  = {30'd0, b90};
                            state_next = S_BLEND;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_BLEND:
            begin
                // 0.9/0.1 blend sum held in prod_reg, divided by ten
                if (op_reg == OP_SINST)
                begin
                    sim_next   = q10[62:35];
                    state_next = S_FIN;
                end
                else
                begin
                    draw_next  = q10[62:35];
                    state_next = S_WIN;
                end
            end
            S_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.release_tick = rel_reg;
                    rsp_next.draw_rate    = draw_reg;
                    rsp_next.sim_rate     = sim_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // launch: a quotient of 2^28 or more saturates without iterating
        dn_hi = {19'd0, dn[NW-1:QB]};
        if (dstart)
        begin
            op_next  = dop;
            dvs_next = dd;
            quo_next = '0;
            low_next = dn[QB-1:0];
            if (dn_hi >= dd)
            begin
                sat_next   = 1'b1;
                state_next = S_DDONE;
            end
            else
            begin
                sat_next   = 1'b0;
                rem_next   = dn_hi;
                step_next  = 5'(QB);
                state_next = S_DIV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            en_reg        <= 1'b0;
            cap_reg       <= 1'b0;
            period_reg    <= 32'd1;
            tps_reg       <= fpr_pkg::TPS_RESET;
            started_reg   <= 1'b0;
            slot_reg      <= '0;
            prev_reg      <= '0;
            wstart_reg    <= '0;
            count_reg     <= '0;
            draw_reg      <= '0;
            sim_reg       <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            op_reg        <= OP_DINST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            slot_reg      <= slot_next;
            prev_reg      <= prev_next;
            wstart_reg    <= wstart_next;
            count_reg     <= count_next;
            draw_reg      <= draw_next;
            sim_reg       <= sim_next;
            step_reg      <= step_next;
            sat_reg       <= sat_next;
            op_reg        <= op_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    fpr_pkg::REG_BLOCK_ENABLE: en_reg     <= cfg_data[0];
                    fpr_pkg::REG_CAP_ENABLE:   cap_reg    <= cfg_data[0];
                    fpr_pkg::REG_FRAME_PERIOD: period_reg <= cfg_data;
                    fpr_pkg::REG_TICKS_PER_S:  tps_reg    <= cfg_data;
                endcase
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        now_reg     <= now_next;
        dt_reg      <= dt_next;
        rel_reg     <= rel_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        low_reg     <= low_next;
        quo_reg     <= quo_next;
        rsp_reg     <= rsp_next;
    end

    // a taken word always starts the sequencer
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == S_PACE))
        else $error("sequencer did not start on a taken word");

    // partial remainder stays below the divisor while iterating
    a_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dvs_reg && step_reg != 5'd0))
        else $error("divider remainder out of range");

    // a stalled result is held
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled result lost");

endmodule

// File: sim/tb_frame_pacer_with_rate_meter.sv
module tb_frame_pacer_with_rate_meter;
    import fpr_pkg::*;

    localparam logic [63:0] TICK_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam int SETTLE = 300;   // cycles past the last result before a register write

    // idle mixes applied per phase
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mix_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    req_t          req = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    rsp_t          rsp;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;

    frame_pacer_with_rate_meter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow registers and pacer/meter state of the predictor
    logic        sh_enable;
    logic        sh_cap;
    logic [63:0] sh_period;
    logic [63:0] sh_tps;
    logic        pm_started;
    logic [63:0] pm_next_slot;
    logic [63:0] pm_prev_rel;
    logic [63:0] pm_win_start;
    logic [63:0] pm_win_count;
    logic [63:0] pm_draw;
    logic [63:0] pm_sim;

    req_t      pending_words[$];
    rsp_t      expected_rsp[$];
    int        n_queued = 0;
    int        n_taken = 0;
    int        n_results = 0;
    int        n_errors = 0;
    idle_mix_t idle_mix = IDLE_NONE;

    function automatic void clear_meters();
        pm_started   = 1'b0;
        pm_next_slot = '0;
        pm_prev_rel  = '0;
        pm_win_start = '0;
        pm_win_count = '0;
        pm_draw      = '0;
        pm_sim       = '0;
    endfunction

    // rounded quotient, clipped to the rate range
    function automatic logic [63:0] rate_quot(logic [127:0] num, logic [63:0] den);
        logic [127:0] q;
        q = (num + {64'd0, den >> 1}) / {64'd0, den};
        return (q > RATE_MAX) ? {36'd0, RATE_MAX} : q[63:0];
    endfunction

    function automatic logic [63:0] ema_90(logic [63:0] old_v, logic [63:0] x);
        return (old_v == 0) ? x : (9 * old_v + x + 5) / 10;
    endfunction

    function automatic logic [63:0] ema_75(logic [63:0] old_v, logic [63:0] x);
        return (old_v == 0) ? x : (3 * old_v + x + 2) / 4;
    endfunction

    function automatic logic [63:0] pace_release(logic [63:0] now);
        logic [63:0] per;
        logic [63:0] rel;
        per = (sh_period == 0) ? 64'd1 : sh_period;
        if (!pm_started)
        begin
            pm_started   = 1'b1;
            pm_next_slot = now + per;
            return now;
        end
        rel = (now > pm_next_slot) ? now : pm_next_slot;
        if (rel > TICK_TOP)
            rel = TICK_TOP;
        if (rel > pm_next_slot + 4 * per)
            pm_next_slot = rel + per;
        else
        begin
            pm_next_slot = pm_next_slot + per;
            if (pm_next_slot < rel)
                pm_next_slot = rel + per;
        end
        return rel;
    endfunction

    function automatic void update_meters(logic [63:0] t, logic [63:0] dt);
        logic [63:0] delta;
        logic [63:0] prod;
        logic [63:0] inst;
        if (pm_prev_rel != 0 && t > pm_prev_rel)
        begin
            delta = t - pm_prev_rel;
            if (delta > sh_tps / 1000000)
                pm_draw = ema_90(pm_draw, rate_quot({64'd0, sh_tps} << 8, delta));
        end
        pm_prev_rel = t;
        if (pm_win_count < 64'hFFFF_FFFF)
            pm_win_count = pm_win_count + 1;
        if (pm_win_start == 0)
            pm_win_start = t;
        else if (t >= pm_win_start && t - pm_win_start >= sh_tps / 4)
        begin
            if (t != pm_win_start)
            begin
                prod = pm_win_count * sh_tps;
                pm_draw = ema_75(pm_draw, rate_quot({64'd0, prod} << 8, t - pm_win_start));
            end
            pm_win_count = '0;
            pm_win_start = t;
        end
        if (dt >= 17)
        begin
            inst = ((64'd1 << 32) + (dt >> 1)) / dt;
            if (inst > RATE_MAX)
                inst = RATE_MAX;
            pm_sim = ema_90(pm_sim, inst);
        end
    endfunction

    function automatic rsp_t predict_release(req_t w);
        rsp_t        r;
        logic [63:0] rel;
        rel = {1'b0, w.now_tick};
        if (sh_enable)
        begin
            if (w.kind)
                clear_meters();
            else if (sh_tps != 0)
            begin
                if (sh_cap)
                    rel = pace_release(rel);
                update_meters(rel, {32'd0, w.sim_frame_time});
            end
        end
        r.release_tick = rel[TICK_W-1:0];
        r.draw_rate    = pm_draw[RATE_W-1:0];
        r.sim_rate     = pm_sim[RATE_W-1:0];
        return r;
    endfunction

    function automatic bit sender_idles();
        case (idle_mix)
            IDLE_SEND: return $urandom_range(0, 99) < 57;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_stalls();
        case (idle_mix)
            IDLE_RECV: return $urandom_range(0, 99) < 57;
            IDLE_BOTH: return $urandom_range(0, 99) < 6;
            default:   return 1'b0;
        endcase
    endfunction

    // driver: a word is taken when valid and not stalled; predict it right then
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
            begin
                expected_rsp.insert(expected_rsp.size(), predict_release(req));
                n_taken++;
            end
            // only move on when the current word is gone or none is offered
            if (!req_valid || !req_stall)
            begin
                if (pending_words.size() != 0 && !sender_idles())
                begin
                    req       <= pending_words.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_results++;
                if (expected_rsp.size() == 0)
                begin
                    $error("unexpected result word %h", rsp);
                    n_errors++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.release_tick !== want.release_tick)
                    begin
                        $error("release_tick expected %h got %h",
                               want.release_tick, rsp.release_tick);
                        n_errors++;
                    end
                    if (rsp.draw_rate !== want.draw_rate)
                    begin
                        $error("draw_rate expected %h got %h", want.draw_rate, rsp.draw_rate);
                        n_errors++;
                    end
                    if (rsp.sim_rate !== want.sim_rate)
                    begin
                        $error("sim_rate expected %h got %h", want.sim_rate, rsp.sim_rate);
                        n_errors++;
                    end
                end
            end
            rsp_stall <= receiver_stalls();
        end
    end

    task automatic queue_word(logic kind, logic [63:0] now, logic [31:0] dt);
        req_t w;
        w.kind           = kind;
        w.now_tick       = now[TICK_W-1:0];
        w.sim_frame_time = dt;
        pending_words.insert(pending_words.size(), w);
        n_queued++;
    endtask

    // wait for every queued word to come back, then let the block settle
    task automatic drain();
        while (n_taken != n_queued || expected_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_BLOCK_ENABLE: sh_enable = val[0];
            REG_CAP_ENABLE:   sh_cap = val[0];
            REG_FRAME_PERIOD: sh_period = {32'd0, val};
            REG_TICKS_PER_S:  sh_tps = {32'd0, val};
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(logic en, logic cap, logic [31:0] per, logic [31:0] tps);
        drain();
        write_reg(REG_BLOCK_ENABLE, {31'd0, en});
        write_reg(REG_CAP_ENABLE, {31'd0, cap});
        write_reg(REG_FRAME_PERIOD, per);
        write_reg(REG_TICKS_PER_S, tps);
    endtask

    // random frame timing around the period: mostly on pace, some late,
    // some early bursts, now and then a backward step or a device reset
    task automatic random_phase(int n, logic [63:0] start, idle_mix_t mix);
        logic [63:0] cur;
        logic [63:0] base;
        logic [63:0] step;
        logic [31:0] dt;
        cur = start;
        base = (sh_period == 0) ? 64'd1 : sh_period;
        idle_mix = mix;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0:       step = base * $urandom_range(5, 9);
                1:       step = $urandom_range(0, 3);
                2:       step = base / $urandom_range(2, 8);
                default: step = base * $urandom_range(60, 140) / 100;
            endcase
            if ($urandom_range(0, 40) == 0)
                cur = (cur > step) ? cur - step : 64'd0;
            else
                cur = (cur + step > TICK_TOP) ? TICK_TOP : cur + step;
            case ($urandom_range(0, 5))
                0:       dt = $urandom;
                1:       dt = $urandom_range(0, 20);
                default: dt = $urandom_range(32'h0004_0000, 32'h0080_0000);
            endcase
            queue_word($urandom_range(0, 60) == 0, cur, dt);
        end
    endtask

    initial
    begin
        #200_000_000;
        $display("frame_pacer_with_rate_meter test failed");
        $finish;
    end

    initial
    begin
        sh_enable = 1'b0;
        sh_cap    = 1'b0;
        sh_period = 64'd1;
        sh_tps    = {32'd0, TPS_RESET};
        clear_meters();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // disabled after reset: pass-through, device reset ignored
        queue_word(1'b0, 64'd1234, 32'd1 << 24);
        queue_word(1'b1, 64'd99, 32'd0);

        // paced with a small period, covering field extremes
        set_regs(1'b1, 1'b1, 32'd1000, 32'd10_000_000);
        queue_word(1'b0, 64'd0, 32'd0);                 // release at tick zero
        queue_word(1'b0, 64'd0, 32'd16);                // early request held to slot
        queue_word(1'b0, 64'd500, 32'd17);
        queue_word(1'b0, 64'd2500, 32'hFFFF_FFFF);
        queue_word(1'b0, 64'd2400, 32'd1 << 24);        // timestamp going backward
        queue_word(1'b0, 64'd20_000, 32'd1 << 20);      // late by more than four periods
        queue_word(1'b0, 64'd20_001, 32'd18);           // one tick later, held to the next slot
        queue_word(1'b0, 64'd3_000_000, 32'd1 << 22);   // window closes
        queue_word(1'b0, TICK_TOP, 32'h5555_5555);
        queue_word(1'b0, TICK_TOP - 5, 32'hAAAA_AAAA);  // slot past the tick range
        queue_word(1'b1, 64'h2AAA_AAAA_AAAA_AAAA, 32'd0);
        queue_word(1'b0, 64'h5555_5555_5555_5555, 32'd1 << 24);
        queue_word(1'b0, 64'h5555_5555_5555_5556, 32'd1 << 24);
        set_regs(1'b1, 1'b1, 32'd0, 32'd3);              // zero period, tiny rate
        queue_word(1'b0, 64'd7, 32'd400);
        queue_word(1'b0, 64'd7, 32'd400);                // same timestamp again, held to the next slot
        queue_word(1'b0, 64'd9, 32'd400);
        set_regs(1'b1, 1'b1, 32'd100, 32'd0);            // zero rate: no pacing
        queue_word(1'b0, 64'd50, 32'd1000);

        set_regs(1'b1, 1'b1, 32'd166_667, 32'd10_000_000);
        random_phase(170, 64'd1_000_000, IDLE_NONE);
        drain();
        random_phase(170, 64'd80_000_000, IDLE_SEND);
        set_regs(1'b1, 1'b0, 32'd166_667, 32'd10_000_000);
        random_phase(150, 64'd5_000, IDLE_RECV);
        set_regs(1'b1, 1'b1, 32'd0, 32'd3);
        random_phase(150, 64'd100, IDLE_BOTH);
        set_regs(1'b1, 1'b1, 32'd5_000, 32'd0);
        random_phase(100, 64'd10, IDLE_NONE);
        set_regs(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(170, TICK_TOP - 64'h0000_0100_0000_0000, IDLE_SEND);
        set_regs(1'b0, 1'b1, 32'd1000, 32'd1_000_000);
        random_phase(80, 64'd777, IDLE_RECV);
        set_regs(1'b1, 1'b1, 32'd1, 32'd1);
        random_phase(150, 64'd1, IDLE_BOTH);
        set_regs(1'b1, 1'b1, 32'd16_667, 32'd1_000_000);
        random_phase(150, 64'd3_000, IDLE_NONE);
        drain();

        $display("%0d words sent, %0d results checked over pacing, bypass and", n_queued,
                 n_results);
        $display("edge register settings with mixed sender and receiver idling");
        if (n_errors == 0)
            $display("frame_pacer_with_rate_meter test passed");
        else
            $display("frame_pacer_with_rate_meter test failed");
        $finish;
    end

endmodule
